FILE: hdl/dbsd_pkg.sv
`timescale 1ns / 1ps

package dbsd_pkg;

	// Default cell width
	localparam int CELL_WIDTH_DEF = 64;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ZERO  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// Division modes
	typedef enum logic [1:0] {
		MODE_UNS,
		MODE_SYM,
		MODE_FLR
	} mode_t;

	// Control word that travels with each item down the pipeline
	typedef struct packed {
		mode_t      mode;
		logic       nneg;
		logic       dneg;
		logic [1:0] status;
	} ctl_t;

endpackage

FILE: hdl/dbsd_prep.sv
`timescale 1ns / 1ps

module dbsd_prep #(
	parameter int CELL_WIDTH = dbsd_pkg::CELL_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_i,
	input  logic [1:0]            opcode,
	input  logic [CELL_WIDTH-1:0] numerator_high,
	input  logic [CELL_WIDTH-1:0] numerator_low,
	input  logic [CELL_WIDTH-1:0] divisor,
	output logic                  vld_s2,
	output logic [CELL_WIDTH-1:0] high_s2,
	output logic [CELL_WIDTH-1:0] low_s2,
	output logic [CELL_WIDTH-1:0] div_s2,
	output dbsd_pkg::ctl_t        ctl_s2
);

	localparam int W = CELL_WIDTH;

	dbsd_pkg::mode_t mode;
	logic            neg_num;
	logic            neg_div;
	logic [2*W-1:0]  num_neg;

	logic            vld_s1;
	logic [W-1:0]    high_s1;
	logic [W-1:0]    low_s1;
	logic [W-1:0]    div_s1;
	dbsd_pkg::mode_t mode_s1;
	logic            nneg_s1;
	logic            dneg_s1;

	logic            nneg_2;
	logic [W-1:0]    high_2;
	logic [1:0]      status_2;

	// Decode the mode; the unused code acts as floored
	always_comb begin
		case (opcode)
			dbsd_pkg::MODE_UNS: mode = dbsd_pkg::MODE_UNS;
			dbsd_pkg::MODE_SYM: mode = dbsd_pkg::MODE_SYM;
			default:            mode = dbsd_pkg::MODE_FLR;
		endcase
	end

	// Work out which operands take their magnitude
	assign neg_num = ((mode == dbsd_pkg::MODE_SYM) && numerator_high[W-1]) ||
		((mode == dbsd_pkg::MODE_FLR) && divisor[W-1]);
	assign neg_div = (mode != dbsd_pkg::MODE_UNS) && divisor[W-1];
	assign num_neg = {(2*W){1'b0}} - {numerator_high, numerator_low};

	// Stage 1: negate the double numerator and the divisor where selected
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		high_s1 <= neg_num ? num_neg[2*W-1:W] : numerator_high;
		low_s1  <= neg_num ? num_neg[W-1:0] : numerator_low;
		div_s1  <= neg_div ? ({W{1'b0}} - divisor) : divisor;
		mode_s1 <= mode;
		nneg_s1 <= (mode == dbsd_pkg::MODE_SYM) && numerator_high[W-1];
		dneg_s1 <= neg_div;
	end

	// Floored mode: fold the divisor into a negative high word
	assign nneg_2 = (mode_s1 == dbsd_pkg::MODE_FLR) ? high_s1[W-1] : nneg_s1;
	assign high_2 = ((mode_s1 == dbsd_pkg::MODE_FLR) && high_s1[W-1]) ?
		(high_s1 + div_s1) : high_s1;

	// Zero divisor first, then the high word range check
	always_comb begin
		if (div_s1 == {W{1'b0}}) begin
			status_2 = dbsd_pkg::ST_ZERO;
		end else if (high_2 >= div_s1) begin
			status_2 = dbsd_pkg::ST_RANGE;
		end else begin
			status_2 = dbsd_pkg::ST_OK;
		end
	end

	// Stage 2: hand the operands to the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		high_s2       <= high_2;
		low_s2        <= low_s1;
		div_s2        <= div_s1;
		ctl_s2.mode   <= mode_s1;
		ctl_s2.nneg   <= nneg_2;
		ctl_s2.dneg   <= dneg_s1;
		ctl_s2.status <= status_2;
	end

endmodule

FILE: hdl/dbsd_cell.sv
`timescale 1ns / 1ps

module dbsd_cell #(
	parameter int CELL_WIDTH = dbsd_pkg::CELL_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_i,
	input  logic [CELL_WIDTH-1:0] rem_i,
	input  logic [CELL_WIDTH-1:0] num_i,
	input  logic [CELL_WIDTH-1:0] div_i,
	input  dbsd_pkg::ctl_t        ctl_i,
	output logic                  vld_q,
	output logic [CELL_WIDTH-1:0] rem_q,
	output logic [CELL_WIDTH-1:0] num_q,
	output logic [CELL_WIDTH-1:0] div_q,
	output dbsd_pkg::ctl_t        ctl_q
);

	localparam int W = CELL_WIDTH;

	logic         carry;
	logic [W-1:0] shifted;
	logic [W:0]   diff;
	logic         take;

	// Shift one numerator bit into the partial remainder and trial-subtract
	assign carry   = rem_i[W-1];
	assign shifted = {rem_i[W-2:0], num_i[W-1]};
	assign diff    = {1'b0, shifted} - {1'b0, div_i};
	assign take    = carry || !diff[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	// Restore on failure; push the quotient bit in at the bottom
	always_ff @(posedge clk) begin
		rem_q <= take ? diff[W-1:0] : shifted;
		num_q <= {num_i[W-2:0], take};
		div_q <= div_i;
		ctl_q <= ctl_i;
	end

endmodule

FILE: hdl/dbsd_post.sv
`timescale 1ns / 1ps

module dbsd_post #(
	parameter int CELL_WIDTH = dbsd_pkg::CELL_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_i,
	input  logic [CELL_WIDTH-1:0] quo_i,
	input  logic [CELL_WIDTH-1:0] rem_i,
	input  dbsd_pkg::ctl_t        ctl_i,
	output logic                  done_q,
	output logic [CELL_WIDTH-1:0] quotient_q,
	output logic [CELL_WIDTH-1:0] remainder_q,
	output logic [1:0]            status_q
);

	localparam int W = CELL_WIDTH;

	logic [W-1:0] quo_neg;
	logic [W-1:0] rem_neg;
	logic [W-1:0] quo_fix;
	logic [W-1:0] rem_fix;
	logic         range;
	logic [1:0]   status_fix;

	assign quo_neg = {W{1'b0}} - quo_i;
	assign rem_neg = {W{1'b0}} - rem_i;

	// Apply the sign rules of each mode and check the quotient range
	always_comb begin
		case (ctl_i.mode)
			dbsd_pkg::MODE_UNS: begin
				quo_fix = quo_i;
				rem_fix = rem_i;
				range   = 1'b0;
			end
			dbsd_pkg::MODE_SYM: begin
				if (ctl_i.nneg != ctl_i.dneg) begin
					quo_fix = quo_neg;
					range   = (quo_neg != {W{1'b0}}) && !quo_neg[W-1];
				end else begin
					quo_fix = quo_i;
					range   = quo_i[W-1];
				end
				rem_fix = ctl_i.nneg ? rem_neg : rem_i;
			end
			default: begin
				quo_fix = quo_i;
				rem_fix = ctl_i.dneg ? rem_neg : rem_i;
				range   = ctl_i.nneg != quo_i[W-1];
			end
		endcase
	end

	// Earlier errors take precedence over the final range check
	always_comb begin
		if (ctl_i.status != dbsd_pkg::ST_OK) begin
			status_fix = ctl_i.status;
		end else if (range) begin
			status_fix = dbsd_pkg::ST_RANGE;
		end else begin
			status_fix = dbsd_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_i;
		end
	end

	// Drop the result fields on any error
	always_ff @(posedge clk) begin
		status_q    <= status_fix;
		quotient_q  <= (status_fix == dbsd_pkg::ST_OK) ? quo_fix : {W{1'b0}};
		remainder_q <= (status_fix == dbsd_pkg::ST_OK) ? rem_fix : {W{1'b0}};
	end

endmodule

FILE: hdl/double_by_single_divider_core.sv
`timescale 1ns / 1ps

// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------------------
// command  | start, busy           | opcode, numerator_high, numerator_low, divisor
// result   | done (strobe)         | quotient, remainder, status
//
// A command transfers at each rising edge with start high and busy low; busy stays
// low, so one command may transfer in every cycle.
// A command passes through two operand preparation stages, one restoring cell per
// quotient bit, and one sign fix-up stage.
// Each result shows for one cycle with done high; the receiver cannot stall it.
// Reset (arst_n low) clears every valid bit; items in flight are dropped.

module double_by_single_divider_core #(
	parameter int CELL_WIDTH = dbsd_pkg::CELL_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            opcode,
	input  logic [CELL_WIDTH-1:0] numerator_high,
	input  logic [CELL_WIDTH-1:0] numerator_low,
	input  logic [CELL_WIDTH-1:0] divisor,
	output logic                  done,
	output logic [CELL_WIDTH-1:0] quotient,
	output logic [CELL_WIDTH-1:0] remainder,
	output logic [1:0]            status
);

	localparam int W = CELL_WIDTH;

	logic                 vld_c [0:W];
	logic [W-1:0]         rem_c [0:W];
	logic [W-1:0]         num_c [0:W];
	logic [W-1:0]         div_c [0:W];
	dbsd_pkg::ctl_t       ctl_c [0:W];

	// The pipeline takes a command in every cycle
	assign busy = 1'b0;

	// Prepare magnitudes and early status
	dbsd_prep #(.CELL_WIDTH(W)) u_prep (
		.clk            (clk),
		.arst_n         (arst_n),
		.vld_i          (start && !busy),
		.opcode         (opcode),
		.numerator_high (numerator_high),
		.numerator_low  (numerator_low),
		.divisor        (divisor),
		.vld_s2         (vld_c[0]),
		.high_s2        (rem_c[0]),
		.low_s2         (num_c[0]),
		.div_s2         (div_c[0]),
		.ctl_s2         (ctl_c[0])
	);

	// One restoring cell per quotient bit
	for (genvar i = 0; i < W; i++) begin : g_cell
		dbsd_cell #(.CELL_WIDTH(W)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (vld_c[i]),
			.rem_i  (rem_c[i]),
			.num_i  (num_c[i]),
			.div_i  (div_c[i]),
			.ctl_i  (ctl_c[i]),
			.vld_q  (vld_c[i+1]),
			.rem_q  (rem_c[i+1]),
			.num_q  (num_c[i+1]),
			.div_q  (div_c[i+1]),
			.ctl_q  (ctl_c[i+1])
		);
	end

	// Fix signs and register the result
	dbsd_post #(.CELL_WIDTH(W)) u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.vld_i       (vld_c[W]),
		.quo_i       (num_c[W]),
		.rem_i       (rem_c[W]),
		.ctl_i       (ctl_c[W]),
		.done_q      (done),
		.quotient_q  (quotient),
		.remainder_q (remainder),
		.status_q    (status)
	);

	// The last cell's divisor copy has no reader downstream
	logic div_tail_unused;
	assign div_tail_unused = ^div_c[W];

endmodule

FILE: hdl/dbsd_chk.sv
`timescale 1ns / 1ps

module dbsd_chk #(
	parameter int CELL_WIDTH = dbsd_pkg::CELL_WIDTH_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic [1:0]            opcode,
	input logic [CELL_WIDTH-1:0] divisor,
	input logic                  done,
	input logic [CELL_WIDTH-1:0] quotient,
	input logic [CELL_WIDTH-1:0] remainder,
	input logic [1:0]            status
);

	localparam int LAT = CELL_WIDTH + 3;
	localparam int CW  = $clog2(LAT + 1);

	logic [CW-1:0] age_q;
	logic          warm;

	// Count cycles since reset, saturating at the latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (age_q != CW'(LAT)) begin
			age_q <= age_q + 1'b1;
		end
	end

	assign warm = (age_q == CW'(LAT));

	// Once warm, done follows the command transfers as delayed through the pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> (done == $past(start && !busy, LAT)))
		else $error("result strobe does not match command transfer");

	// Errored results carry zero fields
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != dbsd_pkg::ST_OK)) |->
			((quotient == '0) && (remainder == '0)))
		else $error("errored result with non-zero fields");

	// Zero-divisor status only for a zero divisor
	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && done && (status == dbsd_pkg::ST_ZERO)) |->
			($past(divisor, LAT) == '0))
		else $error("zero-divisor status with non-zero divisor");

	// Unsigned remainder stays below the divisor
	a_uns_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && done && (status == dbsd_pkg::ST_OK) &&
			($past(opcode, LAT) == dbsd_pkg::MODE_UNS)) |->
			(remainder < $past(divisor, LAT)))
		else $error("unsigned remainder not below divisor");

endmodule

bind double_by_single_divider_core dbsd_chk #(.CELL_WIDTH(CELL_WIDTH)) u_dbsd_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.opcode    (opcode),
	.divisor   (divisor),
	.done      (done),
	.quotient  (quotient),
	.remainder (remainder),
	.status    (status)
);
